FILE: sv/vood_pkg.sv
// Shared types and constants for the voice onset/offset detector.
package vood_pkg;

  // Fixed field widths
  localparam int unsigned ENERGY_W    = 48;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned FLAGS_W     = 6;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  // Saturation limits
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [RUN_W-1:0]    RUN_MAX    = {RUN_W{1'b1}};
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // Register reset values
  localparam logic [COUNT_W-1:0]  WINDOW_LEN_RST      = 13'd441;
  localparam logic [RUN_W-1:0]    RUN_BLOCKS_RST      = 8'd5;
  localparam logic [ENERGY_W-1:0] ENERGY_LIMIT_RST    = 48'd473520144;
  localparam logic [COUNT_W-1:0]  SIGN_LOW_LIMIT_RST  = 13'd18;
  localparam logic [COUNT_W-1:0]  SIGN_HIGH_LIMIT_RST = 13'd52;
  localparam logic [COUNT_W-1:0]  DIR_LOW_LIMIT_RST   = 13'd0;
  localparam logic [COUNT_W-1:0]  DIR_HIGH_LIMIT_RST  = 13'd286;
  localparam logic [FLAGS_W-1:0]  TEST_FLAGS_RST      = 6'd1;

  // Bit positions in test_flags
  localparam int unsigned FLAG_ENERGY    = 0;
  localparam int unsigned FLAG_SIGN_LOW  = 1;
  localparam int unsigned FLAG_SIGN_HIGH = 2;
  localparam int unsigned FLAG_DIR_LOW   = 3;
  localparam int unsigned FLAG_DIR_HIGH  = 4;
  localparam int unsigned FLAG_OFFSET    = 5;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WINDOW_LEN      = 3'd0,
    CFG_RUN_BLOCKS      = 3'd1,
    CFG_ENERGY_LIMIT    = 3'd2,
    CFG_SIGN_LOW_LIMIT  = 3'd3,
    CFG_SIGN_HIGH_LIMIT = 3'd4,
    CFG_DIR_LOW_LIMIT   = 3'd5,
    CFG_DIR_HIGH_LIMIT  = 3'd6,
    CFG_TEST_FLAGS      = 3'd7
  } cfg_idx_e;

  // Three-valued sign: -1, 0, +1
  typedef logic signed [1:0] sgn_t;
  localparam sgn_t SGN_POS  = 2'sb01;
  localparam sgn_t SGN_ZERO = 2'sb00;
  localparam sgn_t SGN_NEG  = 2'sb11;

endpackage

FILE: sv/voice_onset_offset_detector.sv
// Voice onset/offset detector: windowed energy and crossing tests with run detection.
// An accepted sample is held in the input register; the window update then loads its result
// into the result register. Throughput: one sample per cycle unless the result stream stalls;
// the sample is squared in the input stage and added and compared in the next. Reset clears
// all search state and loads register defaults.
module voice_onset_offset_detector #(
  parameter int unsigned MAX_WINDOW  = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  vood_pkg::cfg_idx_e                   cfg_idx_i,
  input  logic [vood_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: sample [SAMPLE_BITS-1:0], zero padded to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // tuser: first [0]
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tlast,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: window_pass [0], run_length [8:1], found [9], boundary_position [41:10],
  //        zero padding [47:42]
  output logic [vood_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tlast: end_of_search
  output logic                                 m_axis_tlast
);
  import vood_pkg::*;

  localparam int unsigned FillW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SqW   = 2 * SAMPLE_BITS;
  localparam logic [31:0] MaxWin32 = 32'(MAX_WINDOW);

  // Configuration registers
  logic [COUNT_W-1:0]  window_len_q, sign_low_limit_q, sign_high_limit_q;
  logic [COUNT_W-1:0]  dir_low_limit_q, dir_high_limit_q;
  logic [RUN_W-1:0]    run_blocks_q;
  logic [ENERGY_W-1:0] energy_limit_q;
  logic [FLAGS_W-1:0]  test_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q      <= WINDOW_LEN_RST;
      run_blocks_q      <= RUN_BLOCKS_RST;
      energy_limit_q    <= ENERGY_LIMIT_RST;
      sign_low_limit_q  <= SIGN_LOW_LIMIT_RST;
      sign_high_limit_q <= SIGN_HIGH_LIMIT_RST;
      dir_low_limit_q   <= DIR_LOW_LIMIT_RST;
      dir_high_limit_q  <= DIR_HIGH_LIMIT_RST;
      test_flags_q      <= TEST_FLAGS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW_LEN:      window_len_q      <= cfg_data_i[COUNT_W-1:0];
        CFG_RUN_BLOCKS:      run_blocks_q      <= cfg_data_i[RUN_W-1:0];
        CFG_ENERGY_LIMIT:    energy_limit_q    <= cfg_data_i[ENERGY_W-1:0];
        CFG_SIGN_LOW_LIMIT:  sign_low_limit_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_SIGN_HIGH_LIMIT: sign_high_limit_q <= cfg_data_i[COUNT_W-1:0];
        CFG_DIR_LOW_LIMIT:   dir_low_limit_q   <= cfg_data_i[COUNT_W-1:0];
        CFG_DIR_HIGH_LIMIT:  dir_high_limit_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_TEST_FLAGS:      test_flags_q      <= cfg_data_i[FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the update stage advances whenever the result register can load
  logic in_valid_q, out_valid_q;
  logic advance, in_accept, step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && advance;

  // Input stage: sample, flags and its square
  logic signed [SAMPLE_BITS-1:0] in_sample, x_q;
  logic [SqW-1:0]                sq_q;
  logic                          first_q, last_q;
  logic signed [SqW-1:0]         sq_full;

  assign in_sample = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign sq_full   = in_sample * in_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q     <= in_sample;
      sq_q    <= unsigned'(sq_full);
      first_q <= s_axis_tuser;
      last_q  <= s_axis_tlast;
    end
  end

  // Search state
  logic [POS_W-1:0]              offset_q, offset_d, begin_q, begin_d, miss_q, miss_d;
  logic [FillW-1:0]              fill_q, fill_d;
  logic [ENERGY_W-1:0]           energy_q, energy_d;
  logic [COUNT_W-1:0]            sign_cnt_q, sign_cnt_d, dir_cnt_q, dir_cnt_d;
  sgn_t                          cur_sign_q, cur_sign_d, prev_dir_q, prev_dir_d;
  logic signed [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [RUN_W-1:0]              run_q, run_d;
  logic                          done_q, done_d;

  // Result fields
  logic                          emit;
  logic                          pass;
  logic                          found;

  // Window update and end-of-window evaluation
  logic [31:0]                   wlen_wide;
  logic [FillW-1:0]              wlen;
  logic [POS_W-1:0]              off0, miss0, begin0;
  logic [FillW-1:0]              fill0, fill_new;
  logic [RUN_W-1:0]              run0;
  logic [ENERGY_W-1:0]           energy0;
  logic [ENERGY_W:0]             energy_sum;
  logic [ENERGY_W-1:0]           energy_new, sq_ext;
  logic [COUNT_W-1:0]            sign0, dir0, sign_new, dir_new;
  sgn_t                          cur0, pdir0, s_x, d_x;
  logic signed [SAMPLE_BITS-1:0] prev0;
  logic signed [SAMPLE_BITS:0]   diff;
  logic                          opening, closed, hit;

  always_comb begin
    // Effective window length, clamped to its legal range
    wlen_wide = 32'(window_len_q);
    if (wlen_wide < 32'd2) begin
      wlen_wide = 32'd2;
    end else if (wlen_wide > MaxWin32) begin
      wlen_wide = MaxWin32;
    end
    wlen = FillW'(wlen_wide);

    // A first sample clears the search before it is processed
    off0  = first_q ? '0 : offset_q;
    fill0 = first_q ? '0 : fill_q;
    run0  = first_q ? '0 : run_q;
    miss0 = first_q ? '0 : miss_q;

    // Opening a new window seeds the accumulators from this sample
    s_x     = (x_q == '0) ? SGN_ZERO : (x_q[SAMPLE_BITS-1] ? SGN_NEG : SGN_POS);
    opening = (fill0 == '0);
    begin0  = opening ? off0 : begin_q;
    energy0 = opening ? '0 : energy_q;
    sign0   = opening ? COUNT_W'(1) : sign_cnt_q;
    dir0    = opening ? COUNT_W'(1) : dir_cnt_q;
    cur0    = opening ? s_x : cur_sign_q;
    prev0   = opening ? x_q : prev_q;
    pdir0   = opening ? SGN_POS : prev_dir_q;

    // Accumulate this sample
    sq_ext     = ENERGY_W'(sq_q);
    energy_sum = {1'b0, energy0} + {1'b0, sq_ext};
    energy_new = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
    diff       = {x_q[SAMPLE_BITS-1], x_q} - {prev0[SAMPLE_BITS-1], prev0};
    d_x        = (diff == '0) ? SGN_ZERO : (diff[SAMPLE_BITS] ? SGN_NEG : SGN_POS);
    sign_new   = ((s_x != cur0) && (sign0 != COUNT_MAX)) ? sign0 + 1'b1 : sign0;
    dir_new    = ((d_x != pdir0) && (dir0 != COUNT_MAX)) ? dir0 + 1'b1 : dir0;
    fill_new   = fill0 + 1'b1;
    closed     = (fill_new >= wlen);

    // Enabled tests; all must pass
    pass = 1'b1;
    if (test_flags_q[FLAG_ENERGY] && !(energy_new > energy_limit_q)) pass = 1'b0;
    if (test_flags_q[FLAG_SIGN_LOW] && !(sign_new < sign_low_limit_q)) pass = 1'b0;
    if (test_flags_q[FLAG_SIGN_HIGH] && !(sign_new > sign_high_limit_q)) pass = 1'b0;
    if (test_flags_q[FLAG_DIR_LOW] && !(dir_new < dir_low_limit_q)) pass = 1'b0;
    if (test_flags_q[FLAG_DIR_HIGH] && !(dir_new > dir_high_limit_q)) pass = 1'b0;
    pass = pass && closed;
    hit  = test_flags_q[FLAG_OFFSET] ? !pass : pass;

    // Run tracking at a window close
    run_d  = run0;
    miss_d = miss0;
    if (closed) begin
      if (hit) begin
        run_d = (run0 != RUN_MAX) ? run0 + 1'b1 : run0;
      end else begin
        run_d  = '0;
        miss_d = begin0;
      end
    end
    found = closed && (run_d > run_blocks_q);

    // Next window state: a closing sample also opens the next window
    if (closed) begin
      begin_d    = off0;
      fill_d     = FillW'(1);
      energy_d   = sq_ext;
      sign_cnt_d = COUNT_W'(1);
      dir_cnt_d  = COUNT_W'(2);
      cur_sign_d = s_x;
      prev_dir_d = SGN_ZERO;
    end else begin
      begin_d    = begin0;
      fill_d     = fill_new;
      energy_d   = energy_new;
      sign_cnt_d = sign_new;
      dir_cnt_d  = dir_new;
      cur_sign_d = (s_x != cur0) ? s_x : cur0;
      prev_dir_d = (d_x != pdir0) ? d_x : pdir0;
    end
    prev_d   = x_q;
    offset_d = off0 + 1'b1;

    // A finished search ignores samples until the next first sample
    emit   = (first_q || !done_q) && (closed || last_q);
    done_d = found || last_q;
  end

  // State register: updated only for samples that are processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      fill_q     <= '0;
      energy_q   <= '0;
      sign_cnt_q <= COUNT_W'(1);
      dir_cnt_q  <= COUNT_W'(1);
      cur_sign_q <= SGN_ZERO;
      prev_q     <= '0;
      prev_dir_q <= SGN_POS;
      run_q      <= '0;
      miss_q     <= '0;
      begin_q    <= '0;
      done_q     <= 1'b0;
    end else if (step && (first_q || !done_q)) begin
      offset_q   <= offset_d;
      fill_q     <= fill_d;
      energy_q   <= energy_d;
      sign_cnt_q <= sign_cnt_d;
      dir_cnt_q  <= dir_cnt_d;
      cur_sign_q <= cur_sign_d;
      prev_q     <= prev_d;
      prev_dir_q <= prev_dir_d;
      run_q      <= run_d;
      miss_q     <= miss_d;
      begin_q    <= begin_d;
      done_q     <= emit && done_d;
    end
  end

  // Result register
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_data_q <= OUT_TDATA_W'({miss_d, found, run_d, pass});
      out_last_q <= done_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: sim/vood_checker.sv
// Result predictor and comparator for the voice onset/offset detector testbench.
module vood_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  vood_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [vood_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [15:0]                      in_data_i,
  input  logic                             in_first_i,
  input  logic                             in_last_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [vood_pkg::OUT_TDATA_W-1:0] out_data_i,
  input  logic                             out_end_i,
  output int                               fail_count_o,
  output int                               outstanding_o,
  output int                               checked_o,
  output int                               detections_o,
  output int                               closings_o
);
  import vood_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_CAP = 4096;
  localparam int          PRINT_CAP  = 40;

  typedef struct packed {
    logic             pass;
    logic [RUN_W-1:0] run_len;
    logic             found;
    logic [POS_W-1:0] boundary;
    logic             closes;
  } boundary_report_t;

  // Copy of the register file
  logic [COUNT_W-1:0]  window_len_q, sign_low_q, sign_high_q, dir_low_q, dir_high_q;
  logic [RUN_W-1:0]    run_blocks_q;
  logic [ENERGY_W-1:0] energy_limit_q;
  logic [FLAGS_W-1:0]  flags_q;

  // Search state
  logic [POS_W-1:0]    offset, miss_pos, win_start;
  logic [COUNT_W-1:0]  fill, sign_cnt, dir_cnt;
  logic [ENERGY_W-1:0] energy;
  sgn_t                cur_sign, prev_dir;
  logic signed [15:0]  prev_x;
  logic [RUN_W-1:0]    hit_run;
  logic                done;

  // Reports predicted but not yet seen on the result stream
  boundary_report_t awaited_reports[$];

  function automatic sgn_t polarity(input logic signed [16:0] v);
    if (v > 0) begin
      return SGN_POS;
    end else if (v < 0) begin
      return SGN_NEG;
    end
    return SGN_ZERO;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count_o++;
    if (fail_count_o <= PRINT_CAP) begin
      $display("[%0t] result %0d: %s is %0d, predicted %0d", $time, checked_o, what, got, want);
    end
  endtask

  task automatic clear_search();
    offset   = '0;
    fill     = '0;
    energy   = '0;
    sign_cnt = COUNT_W'(1);
    dir_cnt  = COUNT_W'(1);
    cur_sign = SGN_ZERO;
    prev_x   = '0;
    prev_dir = SGN_POS;
    hit_run  = '0;
    miss_pos = '0;
    win_start = '0;
    done     = 1'b0;
  endtask

  task automatic open_window(input logic signed [15:0] x);
    win_start = offset;
    fill      = '0;
    energy    = '0;
    sign_cnt  = COUNT_W'(1);
    dir_cnt   = COUNT_W'(1);
    cur_sign  = polarity(17'(x));
    prev_x    = x;
    prev_dir  = SGN_POS;
  endtask

  // Accumulate one sample into the open window; counters and energy saturate.
  task automatic add_sample(input logic signed [15:0] x);
    logic signed [31:0] square;
    logic [ENERGY_W:0]  total;
    sgn_t               s, d;
    square = 32'(x);
    square = square * square;
    total  = {1'b0, energy} + (ENERGY_W+1)'(square[30:0]);
    energy = total[ENERGY_W] ? ENERGY_MAX : total[ENERGY_W-1:0];
    s = polarity(17'(x));
    d = polarity(17'(x) - 17'(prev_x));
    if (s != cur_sign) begin
      cur_sign = s;
      if (sign_cnt != COUNT_MAX) sign_cnt++;
    end
    if (d != prev_dir) begin
      prev_dir = d;
      if (dir_cnt != COUNT_MAX) dir_cnt++;
    end
    prev_x = x;
    fill++;
  endtask

  // A window passes when every enabled test passes.
  function automatic logic window_ok();
    logic ok;
    ok = 1'b1;
    if (flags_q[FLAG_ENERGY] && !(energy > energy_limit_q)) ok = 1'b0;
    if (flags_q[FLAG_SIGN_LOW] && !(sign_cnt < sign_low_q)) ok = 1'b0;
    if (flags_q[FLAG_SIGN_HIGH] && !(sign_cnt > sign_high_q)) ok = 1'b0;
    if (flags_q[FLAG_DIR_LOW] && !(dir_cnt < dir_low_q)) ok = 1'b0;
    if (flags_q[FLAG_DIR_HIGH] && !(dir_cnt > dir_high_q)) ok = 1'b0;
    return ok;
  endfunction

  // Advance the search by one accepted sample and say whether it yields a report.
  task automatic advance_search(input logic signed [15:0] x, input logic first,
                                input logic last, output logic emit,
                                output boundary_report_t rep);
    logic               closed, pass, hit, found;
    logic [COUNT_W-1:0] wlen;
    emit   = 1'b0;
    rep    = '0;
    closed = 1'b0;
    pass   = 1'b0;
    found  = 1'b0;
    if (first) clear_search();
    if (done) return;
    wlen = window_len_q;
    if (wlen < 2) wlen = COUNT_W'(2);
    if (wlen > WINDOW_CAP) wlen = COUNT_W'(WINDOW_CAP);
    if (fill == 0) open_window(x);
    add_sample(x);
    if (fill >= wlen) begin
      closed = 1'b1;
      pass   = window_ok();
      hit    = flags_q[FLAG_OFFSET] ? !pass : pass;
      if (hit) begin
        if (hit_run != RUN_MAX) hit_run++;
      end else begin
        hit_run  = '0;
        miss_pos = win_start;
      end
      found = hit_run > run_blocks_q;
      // The closing sample also opens the next window.
      open_window(x);
      add_sample(x);
    end
    offset++;
    if (!closed && !last) return;
    if (found || last) done = 1'b1;
    emit         = 1'b1;
    rep.pass     = pass;
    rep.run_len  = hit_run;
    rep.found    = found;
    rep.boundary = miss_pos;
    rep.closes   = found || last;
  endtask

  // Watch both streams and the register port on every clock edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    boundary_report_t got, want, fresh;
    logic             emit;
    if (!rst_ni) begin
      window_len_q   = WINDOW_LEN_RST;
      run_blocks_q   = RUN_BLOCKS_RST;
      energy_limit_q = ENERGY_LIMIT_RST;
      sign_low_q     = SIGN_LOW_LIMIT_RST;
      sign_high_q    = SIGN_HIGH_LIMIT_RST;
      dir_low_q      = DIR_LOW_LIMIT_RST;
      dir_high_q     = DIR_HIGH_LIMIT_RST;
      flags_q        = TEST_FLAGS_RST;
      clear_search();
      awaited_reports.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      detections_o  = 0;
      closings_o    = 0;
      outstanding_o <= 0;
    end else begin
      // Compare an accepted result with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        got.pass     = out_data_i[0];
        got.run_len  = out_data_i[8:1];
        got.found    = out_data_i[9];
        got.boundary = out_data_i[41:10];
        got.closes   = out_end_i;
        checked_o++;
        if (awaited_reports.size() == 0) begin
          report_mismatch("result with no pending request", 32'd1, 32'd0);
        end else begin
          want = awaited_reports.pop_front();
          if (want.found) detections_o++;
          if (want.closes && !want.found) closings_o++;
          if (got.pass !== want.pass) begin
            report_mismatch("window_pass", 32'(got.pass), 32'(want.pass));
          end
          if (got.run_len !== want.run_len) begin
            report_mismatch("run_length", 32'(got.run_len), 32'(want.run_len));
          end
          if (got.found !== want.found) begin
            report_mismatch("found", 32'(got.found), 32'(want.found));
          end
          if (got.boundary !== want.boundary) begin
            report_mismatch("boundary_position", got.boundary, want.boundary);
          end
          if (got.closes !== want.closes) begin
            report_mismatch("end_of_search", 32'(got.closes), 32'(want.closes));
          end
        end
      end

      // Register writes land in the predictor's copy.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_LEN:      window_len_q   = cfg_data_i[COUNT_W-1:0];
          CFG_RUN_BLOCKS:      run_blocks_q   = cfg_data_i[RUN_W-1:0];
          CFG_ENERGY_LIMIT:    energy_limit_q = cfg_data_i[ENERGY_W-1:0];
          CFG_SIGN_LOW_LIMIT:  sign_low_q     = cfg_data_i[COUNT_W-1:0];
          CFG_SIGN_HIGH_LIMIT: sign_high_q    = cfg_data_i[COUNT_W-1:0];
          CFG_DIR_LOW_LIMIT:   dir_low_q      = cfg_data_i[COUNT_W-1:0];
          CFG_DIR_HIGH_LIMIT:  dir_high_q     = cfg_data_i[COUNT_W-1:0];
          CFG_TEST_FLAGS:      flags_q        = cfg_data_i[FLAGS_W-1:0];
          default: ;
        endcase
      end

      // Predict the result of an accepted sample request.
      if (in_valid_i && in_ready_i) begin
        advance_search($signed(in_data_i), in_first_i, in_last_i, emit, fresh);
        if (emit) awaited_reports.push_back(fresh);
      end

      outstanding_o <= awaited_reports.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top: clock, reset, sample stimulus, result back-pressure and the verdict.
module tb_top;
  import vood_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SAMPLES = 1850;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int DRAIN_CYCLES   = 6;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_ONE_SIDED,
    SHAPE_ALTERNATE,
    SHAPE_SILENT,
    SHAPE_RAILS,
    SHAPE_RAMP
  } shape_e;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  cfg_idx_e               cfg_idx_i     = CFG_WINDOW_LEN;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [15:0]            s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int fail_count, outstanding, checked, detections, closings;
  int cycle_count    = 0;
  int random_samples = 0;
  int settings_used  = 0;
  int rx_hold        = 0;
  bit gap_on         = 1'b0;
  bit rx_idle_on     = 1'b0;
  bit quiet          = 1'b0;

  voice_onset_offset_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  vood_checker detector_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_first_i    (s_axis_tuser),
    .in_last_i     (s_axis_tlast),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .out_end_i     (m_axis_tlast),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .detections_o  (detections),
    .closings_o    (closings)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random bursts of stalled cycles, none in quiet stretches.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      rx_hold       <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0:       return 8;
      1:       return 300;
      2:       return 6000;
      default: return 32767;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] crossing_limit(input int weff);
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 1) ? 13'd4097 : 13'd0;
    end
    return COUNT_W'($urandom_range(0, weff + 1));
  endfunction

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Load every register; only called while the detector is idle.
  task automatic program_detector(input logic [COUNT_W-1:0] wlen, input logic [RUN_W-1:0] runs,
                                  input logic [ENERGY_W-1:0] elim,
                                  input logic [COUNT_W-1:0] slo, input logic [COUNT_W-1:0] shi,
                                  input logic [COUNT_W-1:0] dlo, input logic [COUNT_W-1:0] dhi,
                                  input logic [FLAGS_W-1:0] flags);
    cfg_write(CFG_WINDOW_LEN, CFG_DATA_W'(wlen));
    cfg_write(CFG_RUN_BLOCKS, CFG_DATA_W'(runs));
    cfg_write(CFG_ENERGY_LIMIT, CFG_DATA_W'(elim));
    cfg_write(CFG_SIGN_LOW_LIMIT, CFG_DATA_W'(slo));
    cfg_write(CFG_SIGN_HIGH_LIMIT, CFG_DATA_W'(shi));
    cfg_write(CFG_DIR_LOW_LIMIT, CFG_DATA_W'(dlo));
    cfg_write(CFG_DIR_HIGH_LIMIT, CFG_DATA_W'(dhi));
    cfg_write(CFG_TEST_FLAGS, CFG_DATA_W'(flags));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // One sample request, optionally after a short idle burst.
  task automatic send_sample(input logic signed [15:0] x, input logic first, input logic last);
    int pause;
    if (gap_on && !quiet && $urandom_range(0, 4) == 0) begin
      pause = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off until every predicted result has arrived and the pipeline is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // A selection of two shaped segments, opened by first and optionally closed by last.
  task automatic run_selection(input int len, input logic closing);
    int     split, amp_a, amp_b, amp, value;
    shape_e shape_a, shape_b, shape;
    split   = $urandom_range(0, len);
    shape_a = shape_e'($urandom_range(0, 5));
    shape_b = shape_e'($urandom_range(0, 5));
    amp_a   = pick_level();
    amp_b   = pick_level();
    for (int i = 0; i < len; i++) begin
      shape = (i < split) ? shape_a : shape_b;
      amp   = (i < split) ? amp_a : amp_b;
      case (shape)
        SHAPE_NOISE:     value = int'($urandom_range(0, 2 * amp)) - amp;
        SHAPE_ONE_SIDED: value = int'($urandom_range(0, amp));
        SHAPE_ALTERNATE: begin
          value = int'($urandom_range(0, amp));
          if (i % 2 == 0) value = -value;
        end
        SHAPE_SILENT:    value = 0;
        SHAPE_RAILS:     value = $urandom_range(0, 1) ? 32767 : -32768;
        default:         value = (i * 37) % (2 * amp + 1) - amp;
      endcase
      send_sample(16'(value), i == 0, closing && (i == len - 1));
    end
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0]  wlen;
    logic [RUN_W-1:0]    runs;
    logic [ENERGY_W-1:0] elim;
    logic [FLAGS_W-1:0]  flags;
    int                  weff, level, phase, cap, len;
    logic                closing;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No test enabled and a window length below the minimum: every window passes.
    program_detector(13'd1, 8'd255, 48'd0, 13'd0, 13'd0, 13'd0, 13'd0, 6'd0);
    send_sample(16'(-32768), 1'b1, 1'b0);
    send_sample(16'(32767), 1'b0, 1'b0);
    send_sample(16'(0), 1'b0, 1'b0);
    send_sample(16'(-1), 1'b0, 1'b0);
    send_sample(16'(1), 1'b0, 1'b1);
    // Search is closed, so this one is dropped.
    send_sample(16'(5), 1'b0, 1'b0);
    // First and last together: a status report with no window closed.
    send_sample(16'(100), 1'b1, 1'b1);
    settle();

    // Offset mode on silence detects at once with no run required.
    program_detector(13'd3, 8'd0, 48'd0, 13'd0, 13'd0, 13'd0, 13'd0,
                     6'((1 << FLAG_OFFSET) | (1 << FLAG_ENERGY)));
    repeat (4) send_sample(16'(0), s_axis_tvalid == 1'b0, 1'b0);
    settle();

    // All four crossing tests enabled at limits that always pass.
    program_detector(13'd4, 8'd1, 48'd0, 13'd4097, 13'd0, 13'd4097, 13'd0,
                     6'((1 << FLAG_SIGN_LOW) | (1 << FLAG_SIGN_HIGH) |
                        (1 << FLAG_DIR_LOW) | (1 << FLAG_DIR_HIGH)));
    for (int i = 0; i < 7; i++) send_sample(16'((i % 2 == 0) ? 10 : -10), i == 0, 1'b0);
    settle();

    // Unreachable energy limit: every window misses.
    program_detector(13'd2, 8'd0, ENERGY_MAX, SIGN_LOW_LIMIT_RST, SIGN_HIGH_LIMIT_RST,
                     DIR_LOW_LIMIT_RST, DIR_HIGH_LIMIT_RST, 6'(1 << FLAG_ENERGY));
    send_sample(16'(32767), 1'b1, 1'b0);
    send_sample(16'(-32768), 1'b0, 1'b0);
    send_sample(16'(32767), 1'b0, 1'b1);

    // Random register settings, each followed by a few selections.
    phase = 0;
    while (random_samples < RANDOM_SAMPLES) begin
      settle();
      quiet      = random_samples > RANDOM_SAMPLES * 85 / 100;
      gap_on     = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;

      cap = $urandom_range(0, 19);
      if (cap < 2) begin
        wlen = 13'($urandom_range(0, 2));
      end else if (cap < 16) begin
        wlen = 13'($urandom_range(3, 12));
      end else begin
        wlen = 13'($urandom_range(13, 48));
      end
      // One pass with an oversized window register, which acts as the largest window.
      if (phase == 3) wlen = 13'd8191;
      weff = (wlen < 2) ? 2 : ((wlen > 4096) ? 4096 : int'(wlen));
      if ($urandom_range(0, 9) == 0) begin
        runs = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end else begin
        runs = 8'($urandom_range(0, 3));
      end
      case ($urandom_range(0, 9))
        0:       elim = '0;
        1:       elim = ENERGY_MAX;
        default: begin
          level = pick_level();
          elim  = 48'(level) * 48'(level) * 48'(weff) / 2;
        end
      endcase
      flags = 6'($urandom_range(0, 63));

      if (phase != 3 && $urandom_range(0, 24) == 0) begin
        // Long unbroken hit streak so the run length saturates.
        program_detector(13'($urandom_range(0, 2)), 8'd255, ENERGY_MAX,
                         13'd0, 13'd0, 13'd0, 13'd0,
                         $urandom_range(0, 1) ? 6'd0 :
                           6'((1 << FLAG_OFFSET) | (1 << FLAG_ENERGY)));
        run_selection(300, 1'b1);
        random_samples += 300;
      end else begin
        program_detector(wlen, runs, elim, crossing_limit(weff), crossing_limit(weff),
                         crossing_limit(weff), crossing_limit(weff), flags);
        repeat ($urandom_range(1, 3)) begin
          cap = ((runs > 3) ? 5 : int'(runs) + 2) * (weff - 1) + 3;
          if (cap > 120) cap = 120;
          len     = $urandom_range(1, cap);
          closing = $urandom_range(0, 9) != 0;
          run_selection(len, closing);
          random_samples += len;
          // Stray samples after a closed search must be dropped.
          if (closing && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              send_sample(16'($urandom), 1'b0, 1'($urandom_range(0, 1)));
            end
          end
        end
      end
      phase++;
    end
    settle();

    $display("Covered %0d random samples under %0d register settings, windows from 2 to 4096.",
             random_samples, settings_used);
    $display("Checked %0d results: %0d detections, %0d searches ended by the final sample.",
             checked, detections, closings);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/vood_pkg.sv
sv/voice_onset_offset_detector.sv
sim/vood_checker.sv
sim/tb_top.sv
